>>> rtl/core/hex_wildcard_signature_parser_core_macros.svh
// Assertion macros shared by the signature parser checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef HEX_WILDCARD_SIGNATURE_PARSER_CORE_MACROS_SVH
`define HEX_WILDCARD_SIGNATURE_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define HWSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hwsp assertion failed");

// next-cycle implication
`define HWSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hwsp assertion failed");

`endif

>>> rtl/core/hwsp_pkg.sv
// Types, constants and the hex digit decoder of the signature parser.
// No dependencies.
package hwsp_pkg;

  localparam int MAX_PATTERN_BYTES = 64;
  localparam int CntW = $clog2(MAX_PATTERN_BYTES + 1);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] MASK_CONC  = 8'hFF;
  localparam logic [7:0] MASK_WILD  = 8'h00;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_HIGH  = 2'd1,
    PH_QMARK = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DANGLING = 3'd1,
    ST_BADHEX   = 3'd2,
    ST_NOBYTES  = 3'd3,
    ST_NOCONC   = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] pattern_value;
    logic [7:0] pattern_mask;
    logic       done_res;
    status_e    status;
    logic       count_overflow;
    logic [6:0] byte_count;
    logic [5:0] first_concrete;
  } out_beat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      h.val = 4'(c - CHAR_0);
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      h.val = 4'(c - CHAR_LA + 8'd10);
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      h.val = 4'(c - CHAR_UA + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/core/hex_wildcard_signature_parser_core.sv
// Byte-signature text parser: one character per beat in, pattern bytes and a
// final report out. A character enters the input register; decode then updates
// the parser state and loads the result register, so a beat is taken every
// cycle while the result register is free, and a result is presented once its
// character has left the input register; the parser state update sets that rate.
// A result beat left waiting in the result register holds the next character in
// the input register, and the input stalls once both are full.
// Characters that yield no byte and are not last give no output beat.
// Depends on hwsp_pkg, hwsp_in_reg, hwsp_parse and hwsp_out_reg.
module hex_wildcard_signature_parser_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hwsp_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hwsp_pkg::out_beat_t out_beat_o
);

  logic                s1_valid, take, free, res_valid;
  hwsp_pkg::in_beat_t  s1_beat;
  hwsp_pkg::out_beat_t res;

  assign take = s1_valid && free;

  hwsp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .take_i     (take),
    .valid_o    (s1_valid),
    .beat_o     (s1_beat)
  );

  hwsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .beat_i      (s1_beat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hwsp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_valid),
    .beat_i      (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

>>> rtl/core/hwsp_in_reg.sv
// Input register stage of the signature parser.
// Depends on hwsp_pkg.
module hwsp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hwsp_pkg::in_beat_t in_beat_i,
  input  logic               take_i,
  output logic               valid_o,
  output hwsp_pkg::in_beat_t beat_o
);

  logic               valid_q, valid_d;
  hwsp_pkg::in_beat_t beat_q;
  logic               fire;

  assign in_ready_o = !valid_q || take_i;
  assign fire       = in_valid_i && in_ready_o;
  assign valid_d    = fire || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      beat_q <= in_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> rtl/core/hwsp_parse.sv
// Parser state and combinational step logic of the signature parser.
// Depends on hwsp_pkg.
module hwsp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  hwsp_pkg::in_beat_t  beat_i,
  output logic                res_valid_o,
  output hwsp_pkg::out_beat_t res_o
);

  localparam int CntW = hwsp_pkg::CntW;

  hwsp_pkg::phase_e  phase_q, phase_d, phase_n;
  hwsp_pkg::status_e err_q, err_d, err_n;
  logic [7:0]        held_q, held_d, held_n;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_n;
  logic              found_q, found_d, found_n;
  logic [5:0]        first_q, first_d, first_n;

  hwsp_pkg::hex_t    hi, lo;
  hwsp_pkg::status_e fin_st;
  logic              is_space, is_q, full, last;
  logic              emit_req, emit_conc, emit_ok;

  assign hi       = hwsp_pkg::hex_decode(held_q);
  assign lo       = hwsp_pkg::hex_decode(beat_i.character);
  assign is_space = beat_i.character == hwsp_pkg::CHAR_SPACE;
  assign is_q     = beat_i.character == hwsp_pkg::CHAR_QMARK;
  assign last     = beat_i.last_char;
  assign full     = cnt_q >= CntW'(hwsp_pkg::MAX_PATTERN_BYTES);
  assign emit_ok  = emit_req && !full;

  // token decode for one character
  always_comb begin
    phase_n   = phase_q;
    err_n     = err_q;
    held_n    = held_q;
    emit_req  = 1'b0;
    emit_conc = 1'b0;
    if (err_q == hwsp_pkg::ST_OK) begin
      if (phase_q == hwsp_pkg::PH_HIGH) begin
        if (is_space) begin
          err_n = hwsp_pkg::ST_DANGLING;
        end else if (!(hi.ok && lo.ok)) begin
          err_n = hwsp_pkg::ST_BADHEX;
        end else begin
          emit_req  = 1'b1;
          emit_conc = 1'b1;
          phase_n   = hwsp_pkg::PH_START;
        end
      end else if (phase_q == hwsp_pkg::PH_QMARK && is_q) begin
        phase_n = hwsp_pkg::PH_START;
      end else begin
        phase_n = hwsp_pkg::PH_START;
        if (is_q) begin
          emit_req = 1'b1;
          if (!full) begin
            phase_n = hwsp_pkg::PH_QMARK;
          end
        end else if (!is_space) begin
          held_n  = beat_i.character;
          phase_n = hwsp_pkg::PH_HIGH;
        end
      end
      if (emit_req && full) begin
        err_n = hwsp_pkg::ST_TOO_LONG;
      end
      if (last && err_n == hwsp_pkg::ST_OK && phase_n == hwsp_pkg::PH_HIGH) begin
        err_n = hwsp_pkg::ST_DANGLING;
      end
    end
  end

  always_comb begin
    cnt_n   = cnt_q + CntW'(emit_ok);
    found_n = found_q;
    first_n = first_q;
    if (emit_ok && emit_conc && !found_q) begin
      found_n = 1'b1;
      first_n = 6'(cnt_q);
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    first_d = first_q;
    if (step_i) begin
      if (last) begin
        phase_d = hwsp_pkg::PH_START;
        err_d   = hwsp_pkg::ST_OK;
        held_d  = 8'd0;
        cnt_d   = '0;
        found_d = 1'b0;
        first_d = 6'd0;
      end else begin
        phase_d = phase_n;
        err_d   = err_n;
        held_d  = held_n;
        cnt_d   = cnt_n;
        found_d = found_n;
        first_d = first_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hwsp_pkg::PH_START;
      err_q   <= hwsp_pkg::ST_OK;
      held_q  <= 8'd0;
      cnt_q   <= '0;
      found_q <= 1'b0;
      first_q <= 6'd0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      first_q <= first_d;
    end
  end

  // result outputs
  always_comb begin
    if (err_n != hwsp_pkg::ST_OK) begin
      fin_st = err_n;
    end else if (cnt_n == '0) begin
      fin_st = hwsp_pkg::ST_NOBYTES;
    end else if (!found_n) begin
      fin_st = hwsp_pkg::ST_NOCONC;
    end else begin
      fin_st = hwsp_pkg::ST_OK;
    end

    res_valid_o = emit_ok || last;
    res_o       = '0;
    if (emit_ok) begin
      res_o.byte_valid    = 1'b1;
      res_o.pattern_value = emit_conc ? {hi.val, lo.val} : 8'd0;
      res_o.pattern_mask  = emit_conc ? hwsp_pkg::MASK_CONC : hwsp_pkg::MASK_WILD;
    end
    if (last) begin
      res_o.done_res       = 1'b1;
      res_o.status         = fin_st;
      res_o.count_overflow = fin_st == hwsp_pkg::ST_TOO_LONG;
      res_o.byte_count     = 7'(cnt_n);
      res_o.first_concrete = (fin_st == hwsp_pkg::ST_OK) ? first_n : 6'd0;
    end
  end

endmodule

>>> rtl/core/hwsp_out_reg.sv
// Result register of the signature parser.
// Depends on hwsp_pkg.
module hwsp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hwsp_pkg::out_beat_t beat_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hwsp_pkg::out_beat_t out_beat_o
);

  logic                valid_q, valid_d;
  hwsp_pkg::out_beat_t beat_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

>>> rtl/core/hwsp_checker.sv
// Port-level checks for the signature parser, bound to the top level.
// Depends on hwsp_pkg and the macro header.
`include "hex_wildcard_signature_parser_core_macros.svh"

module hwsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hwsp_pkg::out_beat_t out_beat_o
);

  `HWSP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_beat_o))

  `HWSP_ASSERT_IMP(a_beat_kind, out_valid_o,
                   out_beat_o.byte_valid || out_beat_o.done_res)

  `HWSP_ASSERT_IMP(a_mid_clean, out_valid_o && !out_beat_o.done_res,
                   out_beat_o.status == hwsp_pkg::ST_OK && out_beat_o.byte_count == 7'd0)

  `HWSP_ASSERT_IMP(a_overflow, out_valid_o && out_beat_o.count_overflow,
                   out_beat_o.done_res && out_beat_o.status == hwsp_pkg::ST_TOO_LONG)

  `HWSP_ASSERT_IMP(a_first_err, out_valid_o && out_beat_o.status != hwsp_pkg::ST_OK,
                   out_beat_o.first_concrete == 6'd0)

endmodule

bind hex_wildcard_signature_parser_core hwsp_checker u_hwsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_beat_o  (out_beat_o)
);
